FILE: src/digital_axis_ramp_unit_assert.svh
// Assertion macros shared by the axis ramp RTL.
`ifndef DIGITAL_AXIS_RAMP_UNIT_ASSERT_SVH
`define DIGITAL_AXIS_RAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DAR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("axis ramp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DAR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("axis ramp assertion failed");

`endif

FILE: src/dar_pkg.sv
// Shared widths, constants and types of the digital axis ramp.
package dar_pkg;

   localparam int TIME_W      = 64;
   localparam int DIGIT_W     = 16;
   localparam int NUM_DIGITS  = TIME_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
   localparam int LEVEL_W     = 15;
   localparam int AXIS_W      = 16;
   localparam int POS_W       = AXIS_W + 1;
   localparam int SUM_W       = AXIS_W + 2;
   localparam int DT_W        = 6;
   localparam int SPAN_W      = 10;
   localparam int DIST_W      = 21;
   localparam int DIV_CNT_W   = $clog2(DIST_W);
   localparam int STEP_W      = 15;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int MODE_W      = 2;

   localparam logic signed [AXIS_W-1:0] FULL_SCALE  = 16'sd32767;
   localparam logic [DT_W-1:0]          MAX_STEP_MS = 6'd50;
   localparam logic [CSR_W-1:0]         RAMP_MIN    = 16'd100;
   localparam logic [CSR_W-1:0]         RAMP_MAX    = 16'd1000;
   localparam logic [CSR_W-1:0]         RAMP_RESET  = 16'd500;

   localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RETURN    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HOLD      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ALIAS     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TIME = 1'b1;

   typedef struct packed {
      logic [LEVEL_W-1:0] lo_level;
      logic [LEVEL_W-1:0] hi_level;
      logic               lo_button_assigned;
      logic               hi_button_assigned;
      logic               lo_pressed;
      logic               hi_pressed;
      logic [TIME_W-1:0]  now_ms;
   } req_beat_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] axis_value;
   } rsp_beat_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] last_ms;
   } delta_ctl_type;

   typedef struct packed {
      logic            done;
      logic [DT_W-1:0] dt;
   } delta_sts_type;

   typedef struct packed {
      logic              start;
      logic [DIST_W-1:0] dividend;
      logic [SPAN_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic              done;
      logic [STEP_W-1:0] quotient;
      logic [SPAN_W-1:0] remainder;
   } div_sts_type;

endpackage

FILE: src/dar_if.sv
// Valid/ready channel interfaces for request and response beats.
interface dar_req_if import dar_pkg::*; ();
   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dar_rsp_if import dar_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/dar_delta.sv
// Digit-serial elapsed-time unit: 64-bit subtract, 16 bits a cycle, capped result.
module dar_delta import dar_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  delta_ctl_type ctl,
   output delta_sts_type sts
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [TIME_W-1:0]      last_ff, last_in;
   logic                   borrow_ff, borrow_in;
   logic                   upper_nz_ff, upper_nz_in;
   logic                   stamp_nz_ff, stamp_nz_in;
   logic                   low_big_ff, low_big_in;
   logic [DT_W-1:0]        low_dt_ff, low_dt_in;
   logic [DIGIT_W:0]       digit_diff;

   assign digit_diff = {1'b0, now_ff[DIGIT_W-1:0]} - {1'b0, last_ff[DIGIT_W-1:0]}
                       - {{DIGIT_W{1'b0}}, borrow_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      now_in      = now_ff;
      last_in     = last_ff;
      borrow_in   = borrow_ff;
      upper_nz_in = upper_nz_ff;
      stamp_nz_in = stamp_nz_ff;
      low_big_in  = low_big_ff;
      low_dt_in   = low_dt_ff;
      if (ctl.start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         now_in      = ctl.now_ms;
         last_in     = ctl.last_ms;
         borrow_in   = 1'b0;
         upper_nz_in = 1'b0;
         stamp_nz_in = 1'b0;
         low_big_in  = 1'b0;
         low_dt_in   = '0;
      end else if (busy_ff) begin
         borrow_in   = digit_diff[DIGIT_W];
         stamp_nz_in = stamp_nz_ff | (last_ff[DIGIT_W-1:0] != '0);
         if (cnt_ff == '0) begin
            low_big_in = digit_diff[DIGIT_W-1:0] > {{(DIGIT_W-DT_W){1'b0}}, MAX_STEP_MS};
            low_dt_in  = digit_diff[DT_W-1:0];
         end else begin
            upper_nz_in = upper_nz_ff | (digit_diff[DIGIT_W-1:0] != '0);
         end
         // advance to the next digit
         now_in  = {{DIGIT_W{1'b0}}, now_ff[TIME_W-1:DIGIT_W]};
         last_in = {{DIGIT_W{1'b0}}, last_ff[TIME_W-1:DIGIT_W]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIGIT_CNT_W'(NUM_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff      <= cnt_in;
      now_ff      <= now_in;
      last_ff     <= last_in;
      borrow_ff   <= borrow_in;
      upper_nz_ff <= upper_nz_in;
      stamp_nz_ff <= stamp_nz_in;
      low_big_ff  <= low_big_in;
      low_dt_ff   <= low_dt_in;
   end

   // an unstamped timer gives zero elapsed time
   assign sts.done = done_ff;
   assign sts.dt   = !stamp_nz_ff ? '0 :
                     (upper_nz_ff || low_big_ff) ? MAX_STEP_MS : low_dt_ff;

endmodule

FILE: src/dar_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module dar_divider import dar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIST_W-1:0]    quo_ff, quo_in;
   logic [SPAN_W-1:0]    divisor_ff, divisor_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [SPAN_W:0]      trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIST_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (ctl.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = ctl.dividend;
         divisor_in = ctl.divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         // shift the dividend out and the quotient bit in
         quo_in = {quo_ff[DIST_W-2:0], fits};
         rem_in = fits ? SPAN_W'(trial - {1'b0, divisor_ff}) : trial[SPAN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIST_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff[STEP_W-1:0];
   assign sts.remainder = rem_ff;

endmodule

FILE: src/digital_axis_ramp_unit.sv
// Top level of the digital axis ramp: control sequencer, ramp state and output stage.
//
// Each request beat is one poll of an axis: two analog levels, button bindings and
// presses, and a millisecond timestamp; each poll returns exactly one response beat
// carrying hi_level - lo_level plus the digital part, saturated to 16 bits. In
// immediate mode (mode 0 or 3), or with no button bound, a poll goes from IDLE
// straight to FINISH. In the two gradual modes it passes through START, DELTA and
// DIVIDE: the 64-bit elapsed-time subtract, done 16 bits a cycle, then the
// bit-serial division of the slew distance by the clamped ramp time. One poll is
// worked on at a time; a finished response waits in its own output register, so
// the next request is taken while the previous response still waits. Write
// axis_mode (index 0) and ramp_time_ms (index 1) on the csr port only while the
// block is idle.
module digital_axis_ramp_unit import dar_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dar_req_if.sink              req_chan,
   dar_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "digital_axis_ramp_unit_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DELTA,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   logic [MODE_W-1:0]          axis_mode_ff;
   logic [CSR_W-1:0]           ramp_time_ff;
   logic signed [AXIS_W-1:0]   ramp_position_ff;
   logic [SPAN_W-1:0]          ramp_remainder_ff;
   logic [TIME_W-1:0]          last_time_ff;
   logic [MODE_W-1:0]          held_mode_ff;

   // poll payload, held for the duration of the poll; dig_ff takes the new ramp position when the division is done
   logic [LEVEL_W-1:0]         lo_ff;
   logic [LEVEL_W-1:0]         hi_ff;
   logic                       dir_up_ff;
   logic                       dir_dn_ff;
   logic [TIME_W-1:0]          now_ff;
   logic signed [AXIS_W-1:0]   dig_ff;

   logic                       rsp_valid_ff;
   rsp_beat_type               rsp_beat_ff;

   delta_ctl_type              delta_ctl;
   delta_sts_type              delta_sts;
   div_ctl_type                div_ctl;
   div_sts_type                div_sts;

   logic                       req_fire;
   logic [MODE_W-1:0]          mode_eff;
   logic                       assigned;
   logic                       req_up;
   logic                       req_dn;
   logic                       clear_ramp;
   logic [SPAN_W-1:0]          span;
   logic signed [POS_W-1:0]    pos_ext;
   logic signed [POS_W-1:0]    target;
   logic signed [POS_W-1:0]    step_ext;
   logic signed [POS_W-1:0]    pos_up;
   logic signed [POS_W-1:0]    pos_dn;
   logic signed [POS_W-1:0]    pos_next;
   logic signed [SUM_W-1:0]    sum;
   logic signed [AXIS_W-1:0]   sum_sat;
   logic                       out_free;

   // ---------------------------------------------------------------------------
   // Handshake and request decode
   // ---------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // mode 3 behaves as immediate everywhere
   assign mode_eff   = (axis_mode_ff == MODE_ALIAS) ? MODE_IMMEDIATE : axis_mode_ff;
   assign assigned   = req_chan.data.lo_button_assigned | req_chan.data.hi_button_assigned;
   assign req_up     = req_chan.data.hi_pressed & ~req_chan.data.lo_pressed;
   assign req_dn     = req_chan.data.lo_pressed & ~req_chan.data.hi_pressed;
   // mode change, no binding or immediate mode: drop the ramp and restamp
   assign clear_ramp = (mode_eff != held_mode_ff) || !assigned ||
                       (mode_eff == MODE_IMMEDIATE);

   // ramp time clamped to 100..1000
   assign span = (ramp_time_ff > RAMP_MAX) ? RAMP_MAX[SPAN_W-1:0] :
                 (ramp_time_ff < RAMP_MIN) ? RAMP_MIN[SPAN_W-1:0] :
                 ramp_time_ff[SPAN_W-1:0];

   // ---------------------------------------------------------------------------
   // Serial units
   // ---------------------------------------------------------------------------
   assign delta_ctl.start   = (state_ff == ST_START);
   assign delta_ctl.now_ms  = now_ff;
   assign delta_ctl.last_ms = last_time_ff;

   dar_delta u_delta (
      .clock (clock),
      .reset (reset),
      .ctl   (delta_ctl),
      .sts   (delta_sts)
   );

   // slew distance: 32767 * dt + carried remainder, below 2^21
   assign div_ctl.start    = (state_ff == ST_DELTA) && delta_sts.done;
   assign div_ctl.dividend = {delta_sts.dt, {(DIST_W-DT_W){1'b0}}}
                             - {{(DIST_W-DT_W){1'b0}}, delta_sts.dt}
                             + {{(DIST_W-SPAN_W){1'b0}}, ramp_remainder_ff};
   assign div_ctl.divisor  = span;

   dar_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // ---------------------------------------------------------------------------
   // Position update: step toward the target, never past it
   // ---------------------------------------------------------------------------
   assign pos_ext  = POS_W'(ramp_position_ff);
   assign step_ext = $signed({{(POS_W-STEP_W){1'b0}}, div_sts.quotient});
   always_comb begin
      if (dir_up_ff) begin
         target = POS_W'(FULL_SCALE);
      end else if (dir_dn_ff) begin
         target = -POS_W'(FULL_SCALE);
      end else if (held_mode_ff == MODE_RETURN) begin
         target = '0;
      end else begin
         // hold mode keeps its place
         target = pos_ext;
      end
   end

   assign pos_up = pos_ext + step_ext;
   assign pos_dn = pos_ext - step_ext;
   always_comb begin
      if (pos_ext < target) begin
         pos_next = (pos_up < target) ? pos_up : target;
      end else if (pos_ext > target) begin
         pos_next = (pos_dn > target) ? pos_dn : target;
      end else begin
         pos_next = pos_ext;
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: analog difference plus digital part, saturated
   // ---------------------------------------------------------------------------
   assign sum = $signed({3'b000, hi_ff}) - $signed({3'b000, lo_ff}) + SUM_W'(dig_ff);
   always_comb begin
      if (sum > SUM_W'(FULL_SCALE)) begin
         sum_sat = FULL_SCALE;
      end else if (sum < -SUM_W'(FULL_SCALE) - SUM_W'(1)) begin
         sum_sat = -FULL_SCALE - AXIS_W'(1);
      end else begin
         sum_sat = sum[AXIS_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_beat_ff;

   // ---------------------------------------------------------------------------
   // Sequencer, ramp state, configuration and registered outputs
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         axis_mode_ff      <= MODE_IMMEDIATE;
         ramp_time_ff      <= RAMP_RESET;
         ramp_position_ff  <= '0;
         ramp_remainder_ff <= '0;
         last_time_ff      <= '0;
         held_mode_ff      <= MODE_IMMEDIATE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AXIS_MODE: begin
                  axis_mode_ff <= csr_wdata[MODE_W-1:0];
               end
               CSR_RAMP_TIME: begin
                  ramp_time_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end

         // drop the response once it is taken, unless the next one loads now
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (clear_ramp) begin
                     held_mode_ff      <= mode_eff;
                     ramp_position_ff  <= '0;
                     ramp_remainder_ff <= '0;
                     last_time_ff      <= req_chan.data.now_ms;
                  end
                  if (!assigned || mode_eff == MODE_IMMEDIATE) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_START;
                  end
               end
            end
            ST_START: begin
               // the delta unit has its own copy of the old stamp
               last_time_ff <= now_ff;
               state_ff     <= ST_DELTA;
            end
            ST_DELTA: begin
               if (delta_sts.done) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_sts.done) begin
                  ramp_position_ff  <= pos_next[AXIS_W-1:0];
                  ramp_remainder_ff <= (pos_next == target) ? '0 : div_sts.remainder;
                  state_ff          <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         lo_ff     <= req_chan.data.lo_level;
         hi_ff     <= req_chan.data.hi_level;
         dir_up_ff <= req_up;
         dir_dn_ff <= req_dn;
         now_ff    <= req_chan.data.now_ms;
         if (assigned && mode_eff == MODE_IMMEDIATE) begin
            dig_ff <= req_up ? FULL_SCALE : (req_dn ? -FULL_SCALE : '0);
         end else begin
            dig_ff <= '0;
         end
      end else if (state_ff == ST_DIVIDE && div_sts.done) begin
         dig_ff <= pos_next[AXIS_W-1:0];
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_beat_ff.axis_value <= sum_sat;
      end
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `DAR_ASSERT_SAME(a_pos_in_range, clock, reset, 1'b1, ramp_position_ff >= -FULL_SCALE)
   `DAR_ASSERT_SAME(a_rem_in_range, clock, reset, 1'b1, ramp_remainder_ff < RAMP_MAX[SPAN_W-1:0])
   `DAR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != ST_IDLE)
   `DAR_ASSERT_SAME(a_div_done_in_divide, clock, reset, div_sts.done, state_ff == ST_DIVIDE)

endmodule

FILE: dv/axis_value_checker.sv
// Axis value checker: predicts each response beat of the axis ramp unit and compares it.
`timescale 1ns / 100ps

module axis_value_checker import dar_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dar_req_if                   req_mon,
   dar_rsp_if                   rsp_mon,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);

   // Register copies, as last written on the csr port.
   logic [MODE_W-1:0] mode_sel;
   logic [CSR_W-1:0]  ramp_ms;

   // Ramp state.
   int                ramp_pos;
   logic [SPAN_W-1:0] ramp_rem;
   logic [TIME_W-1:0] stamp_ms;
   logic [MODE_W-1:0] held_mode;

   logic signed [AXIS_W-1:0] expected_axis_q[$];
   int                       mismatches = 0;

   function automatic void clear_ramp(input logic [MODE_W-1:0] mode,
                                      input logic [TIME_W-1:0] now);
      held_mode = mode;
      ramp_pos  = 0;
      ramp_rem  = '0;
      stamp_ms  = now;
   endfunction

   // Advance the position toward target by the time elapsed since the last stamp.
   function automatic int slew_to(input int target, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] dt;
      longint unsigned   span;
      longint unsigned   slew_dist;
      int                step;
      int                next_pos;
      if (stamp_ms == '0) stamp_ms = now;
      dt = now - stamp_ms;
      if (dt > TIME_W'(MAX_STEP_MS)) dt = TIME_W'(MAX_STEP_MS);
      stamp_ms = now;
      span = (ramp_ms > RAMP_MAX) ? RAMP_MAX : (ramp_ms < RAMP_MIN) ? RAMP_MIN : ramp_ms;
      slew_dist = 64'd32767 * dt + ramp_rem;
      step = int'(slew_dist / span);
      ramp_rem = SPAN_W'(slew_dist % span);
      if (ramp_pos < target) begin
         next_pos = ramp_pos + step;
         ramp_pos = (next_pos < target) ? next_pos : target;
      end else if (ramp_pos > target) begin
         next_pos = ramp_pos - step;
         ramp_pos = (next_pos > target) ? next_pos : target;
      end
      if (ramp_pos == target) ramp_rem = '0;
      return ramp_pos;
   endfunction

   function automatic logic signed [AXIS_W-1:0] predict_axis_value(input req_beat_type beat);
      logic [MODE_W-1:0]        mode;
      int                       dir;
      int                       digital;
      int                       sum;
      logic signed [AXIS_W-1:0] axis;
      mode    = (mode_sel == MODE_ALIAS) ? MODE_IMMEDIATE : mode_sel;
      dir     = int'(beat.hi_pressed) - int'(beat.lo_pressed);
      digital = 0;
      if (mode != held_mode) clear_ramp(mode, beat.now_ms);
      if (!(beat.lo_button_assigned || beat.hi_button_assigned)) begin
         clear_ramp(mode, beat.now_ms);
      end else if (mode == MODE_IMMEDIATE) begin
         clear_ramp(mode, beat.now_ms);
         digital = dir * int'(FULL_SCALE);
      end else if (dir != 0) begin
         digital = slew_to(dir * int'(FULL_SCALE), beat.now_ms);
      end else if (mode == MODE_RETURN) begin
         digital = slew_to(0, beat.now_ms);
      end else begin
         digital = slew_to(ramp_pos, beat.now_ms);
      end
      sum = int'(beat.hi_level) - int'(beat.lo_level) + digital;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      axis = sum[AXIS_W-1:0];
      return axis;
   endfunction

   always @(posedge clock) begin : watch
      logic signed [AXIS_W-1:0] want;
      if (reset) begin
         mode_sel  = MODE_IMMEDIATE;
         ramp_ms   = RAMP_RESET;
         clear_ramp(MODE_IMMEDIATE, '0);
         expected_axis_q.delete();
      end else begin
         // Compare first, so a response never meets a poll accepted at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_axis_q.size() == 0) begin
               $display("%0t: axis_value %0d arrived with no poll outstanding",
                        $time, rsp_mon.data.axis_value);
               mismatches++;
            end else begin
               want = expected_axis_q.pop_front();
               if (rsp_mon.data.axis_value !== want) begin
                  $display("%0t: axis_value expected %0d, got %0d",
                           $time, want, rsp_mon.data.axis_value);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AXIS_MODE: mode_sel = csr_wdata[MODE_W-1:0];
               CSR_RAMP_TIME: ramp_ms  = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_axis_q.push_back(predict_axis_value(req_mon.data));
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_axis_q.size();
   end

endmodule

FILE: dv/testbench.sv
// Top of the axis ramp testbench: clock, reset, poll stimulus, response stalls and verdict.
`timescale 1ns / 100ps

module testbench;
   import dar_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   dar_req_if req_chan ();
   dar_rsp_if rsp_chan ();

   int mismatch_count;
   int pending_count;

   // Idle and stall rates in percent, changed per phase.
   int idle_pct  = 0;
   int stall_pct = 0;

   // Pulse to make the receiver hold off for a long stretch.
   logic holdoff_req = 1'b0;
   int   holdoff_left;

   int                polls_sent = 0;
   logic [TIME_W-1:0] wall_ms;

   digital_axis_ramp_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   axis_value_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run: far beyond the slowest legal run of this stimulus.
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Response side: stall at random, or hold off entirely while a long stall
   // is requested, so that the output register fills and the block stops
   // taking polls while the sender keeps offering them.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left   <= 0;
      end else if (holdoff_req) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left   <= 300;
      end else if (holdoff_left != 0) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left   <= holdoff_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one poll beat, idling at random first; return at the edge that takes it.
   task automatic send_poll(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                            input logic lo_asg, input logic hi_asg,
                            input logic lo_prs, input logic hi_prs,
                            input logic [TIME_W-1:0] now);
      req_beat_type beat;
      beat = '{lo, hi, lo_asg, hi_asg, lo_prs, hi_prs, now};
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= beat;
      // ready is sampled as it stands at the edge, before the block updates
      @(posedge clock iff req_chan.ready);
      polls_sent++;
   endtask

   // Wait until every response is back and the block has gone idle.
   task automatic wait_drained();
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges; hold the enable across them.
   task automatic write_config(input logic [MODE_W-1:0] mode, input logic [CSR_W-1:0] ramp);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_AXIS_MODE;
      csr_wdata <= CSR_W'(mode);
      @(posedge clock);
      csr_index <= CSR_RAMP_TIME;
      csr_wdata <= ramp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly quiet analog levels, so the digital ramp shows; sometimes full range.
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(3))
         0, 1:    return '0;
         2:       return LEVEL_W'($urandom_range(200));
         default: return LEVEL_W'($urandom_range(32767));
      endcase
   endfunction

   // Press pattern {lo, hi}: mostly a single side, so the ramp moves.
   function automatic logic [1:0] pick_press();
      int r;
      r = $urandom_range(9);
      if (r < 4) return 2'b01;
      if (r < 8) return 2'b10;
      if (r == 8) return 2'b00;
      return 2'b11;
   endfunction

   // Advance the millisecond clock: mostly small steps, sometimes backward,
   // sometimes a long jump or a wild value.
   task automatic advance_wall();
      int r;
      r = $urandom_range(99);
      if (r < 85)      wall_ms = wall_ms + $urandom_range(60);
      else if (r < 92) wall_ms = wall_ms - $urandom_range(1, 100);
      else if (r < 97) wall_ms = wall_ms + $urandom_range(51, 100000);
      else             wall_ms = {$urandom, $urandom};
   endtask

   // One held-button sequence: a press pattern for a while, then another,
   // with steady bindings and a clock that mostly moves forward.
   task automatic run_poll_burst();
      int         len;
      int         split;
      int         asg_pick;
      logic       lo_asg;
      logic       hi_asg;
      logic [1:0] press_a;
      logic [1:0] press_b;
      logic [1:0] press;
      len      = $urandom_range(4, 40);
      split    = $urandom_range(len);
      asg_pick = $urandom_range(19);
      lo_asg   = (asg_pick != 0) && (asg_pick < 7 || asg_pick >= 13);
      hi_asg   = (asg_pick != 0) && (asg_pick >= 7);
      press_a  = pick_press();
      press_b  = pick_press();
      for (int i = 0; i < len; i++) begin
         press = (i < split) ? press_a : press_b;
         advance_wall();
         send_poll(pick_level(), pick_level(), lo_asg, hi_asg, press[1], press[0], wall_ms);
      end
   endtask

   initial begin
      logic [MODE_W-1:0] phase_mode [8];
      logic [CSR_W-1:0]  phase_ramp [8];
      int                send_idle [4];
      int                recv_stall [4];
      int                goal;
      int                drain_cycles;

      phase_mode = '{MODE_RETURN, MODE_HOLD, MODE_IMMEDIATE, MODE_ALIAS,
                     MODE_RETURN, MODE_HOLD, MODE_RETURN, MODE_HOLD};
      phase_ramp = '{16'd100, 16'd1000, 16'hFFFF, 16'd0, 16'hFFFF,
                     CSR_W'($urandom_range(99)), CSR_W'($urandom),
                     CSR_W'($urandom_range(100, 1000))};
      send_idle  = '{0, 45, 0, 35};
      recv_stall = '{0, 0, 45, 35};

      // Drive every input to a known value before the first edge.
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_AXIS_MODE;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed polls in immediate mode at reset settings: saturation both
      // ways, no binding at all, and both sides pressed at once.
      send_poll(15'd0, 15'd32767, 1'b0, 1'b1, 1'b0, 1'b1, 64'd0);
      send_poll(15'd32767, 15'd0, 1'b1, 1'b0, 1'b1, 1'b0, 64'd7);
      send_poll(15'd100, 15'd5, 1'b0, 1'b0, 1'b1, 1'b1, 64'd9);
      send_poll(15'd3, 15'd40, 1'b1, 1'b1, 1'b1, 1'b1, 64'd11);
      req_chan.valid <= 1'b0;
      wait_drained();

      // Gradual return at the shortest ramp: unstamped timer at zero, a
      // capped step, reaching the edge, time running backward, release back
      // to center, and a wrap from the top of the time range.
      write_config(MODE_RETURN, 16'd100);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd0);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd50);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd1000);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd1050);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd1049);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b0, 64'd1099);
      send_poll(15'd0, 15'd0, 1'b0, 1'b1, 1'b0, 1'b0, 64'd1149);
      send_poll(15'd0, 15'd0, 1'b1, 1'b0, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      req_chan.valid <= 1'b0;
      wait_drained();

      // Gradual hold at the longest ramp: the mode change clears the ramp,
      // release keeps the place, both pressed holds, no binding clears.
      write_config(MODE_HOLD, 16'd1000);
      send_poll(15'd0, 15'd0, 1'b1, 1'b1, 1'b0, 1'b1, 64'd2000);
      send_poll(15'd0, 15'd0, 1'b1, 1'b1, 1'b0, 1'b1, 64'd2030);
      send_poll(15'd0, 15'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd2060);
      send_poll(15'd0, 15'd0, 1'b1, 1'b1, 1'b1, 1'b1, 64'd2080);
      send_poll(15'd0, 15'd0, 1'b1, 1'b1, 1'b1, 1'b0, 64'd2100);
      send_poll(15'd0, 15'd0, 1'b0, 1'b0, 1'b1, 1'b0, 64'd2110);
      req_chan.valid <= 1'b0;
      wait_drained();

      // Mode value three behaves as immediate.
      write_config(MODE_ALIAS, 16'd500);
      send_poll(15'd1, 15'd0, 1'b0, 1'b1, 1'b0, 1'b1, 64'd2200);
      send_poll(15'd0, 15'd0, 1'b1, 1'b0, 1'b1, 1'b0, 64'd2210);
      req_chan.valid <= 1'b0;
      wait_drained();

      // Random phases: one register setting each, cycling through the idle
      // and stall patterns; phases zero and four start with a long hold-off.
      wall_ms = 64'd5000;
      for (int p = 0; p < 8; p++) begin
         write_config(phase_mode[p], phase_ramp[p]);
         idle_pct  <= send_idle[p % 4];
         stall_pct <= recv_stall[p % 4];
         if (p % 4 == 0) begin
            holdoff_req <= 1'b1;
            @(posedge clock);
            holdoff_req <= 1'b0;
         end
         goal = polls_sent + 100;
         while (polls_sent < goal) begin
            if ($urandom_range(99) < 85) begin
               run_poll_burst();
            end else begin
               // Noise: any field may take any value.
               send_poll(LEVEL_W'($urandom), LEVEL_W'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), {$urandom, $urandom});
            end
         end
         req_chan.valid <= 1'b0;
         stall_pct      <= 0;
         wait_drained();
      end

      // Drain: give the last responses time to arrive, then a short tail.
      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/dar_pkg.sv
src/dar_if.sv
src/dar_delta.sv
src/dar_divider.sv
src/digital_axis_ramp_unit.sv
dv/axis_value_checker.sv
dv/testbench.sv
